// ----- rtl/owb_pkg.sv -----
package owb_pkg;

  localparam int REG_W      = 10;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int CMD_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 16;

  // command codes (carried in s_axis_tuser)
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESET_RECOVER = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_LOW     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_HOLD    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_READ_LOW      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_READ_RECOVER  = 3'd7;

  // reset values, in ticks
  localparam logic [REG_W-1:0] RST_RESET_LOW     = 10'd500;
  localparam logic [REG_W-1:0] RST_PRESENCE_WAIT = 10'd70;
  localparam logic [REG_W-1:0] RST_RESET_RECOVER = 10'd500;
  localparam logic [REG_W-1:0] RST_WRITE_LOW     = 10'd10;
  localparam logic [REG_W-1:0] RST_WRITE_HOLD    = 10'd50;
  localparam logic [REG_W-1:0] RST_READ_LOW      = 10'd8;
  localparam logic [REG_W-1:0] RST_READ_SAMPLE   = 10'd8;
  localparam logic [REG_W-1:0] RST_READ_RECOVER  = 10'd48;

  typedef struct packed {
    logic [REG_W-1:0] reset_low_ticks;
    logic [REG_W-1:0] presence_wait_ticks;
    logic [REG_W-1:0] reset_recover_ticks;
    logic [REG_W-1:0] write_low_ticks;
    logic [REG_W-1:0] write_hold_ticks;
    logic [REG_W-1:0] read_low_ticks;
    logic [REG_W-1:0] read_sample_ticks;
    logic [REG_W-1:0] read_recover_ticks;
  } owb_cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
    logic              line_in;
  } owb_item_t;

  typedef struct packed {
    logic              bus_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
    logic              presence_level;
  } owb_res_t;

endpackage

// ----- rtl/one_wire_bus_master.sv -----
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser cmd, tdata byte + line level
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata line drive and status
// cfg       in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One result per transaction; an item is taken every cycle when the output drains.
// Each item passes through the input register and the sequencer step into the result register.
// The sequencer state advances only when an item moves into the result register,
// so a stall on m_axis freezes the bus timing with it.
// rst_ni clears the sequencer, loads the default tick counts and empties both stages.
module one_wire_bus_master
  import owb_pkg::*;
#(
  parameter int COUNT_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] data_byte, [8] line_in
  input  logic [CMD_W-1:0]     s_axis_tuser,   // [1:0] cmd
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] bus_low, [1] busy_res, [2] done_res, [10:3] read_byte, [11] presence_level
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  owb_cfg_t  cfg;
  owb_item_t item_q, item_d;
  owb_res_t  res_q, res_next;
  logic      in_vld_q, in_vld_d;
  logic      out_vld_q, out_vld_d;
  logic      adv;
  logic      s_acc;

  owb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  owb_sequencer #(
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_next)
  );

  assign adv           = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | adv;
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  assign item_d.cmd       = s_axis_tuser;
  assign item_d.data_byte = s_axis_tdata[BYTE_W-1:0];
  assign item_d.line_in   = s_axis_tdata[BYTE_W];

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_acc) in_vld_d = 1'b1;
    else if (adv) in_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (adv) out_vld_d = 1'b1;
    else if (m_axis_tready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) item_q <= item_d;
    if (adv)   res_q  <= res_next;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, res_q.presence_level, res_q.read_byte,
                          res_q.done_res, res_q.busy_res, res_q.bus_low};

endmodule

// ----- rtl/owb_cfg_regs.sv -----
module owb_cfg_regs
  import owb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  output owb_cfg_t             cfg_o
);

  owb_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RESET_LOW:     cfg_d.reset_low_ticks     = cfg_data_i;
        REG_PRESENCE_WAIT: cfg_d.presence_wait_ticks = cfg_data_i;
        REG_RESET_RECOVER: cfg_d.reset_recover_ticks = cfg_data_i;
        REG_WRITE_LOW:     cfg_d.write_low_ticks     = cfg_data_i;
        REG_WRITE_HOLD:    cfg_d.write_hold_ticks    = cfg_data_i;
        REG_READ_LOW:      cfg_d.read_low_ticks      = cfg_data_i;
        REG_READ_SAMPLE:   cfg_d.read_sample_ticks   = cfg_data_i;
        REG_READ_RECOVER:  cfg_d.read_recover_ticks  = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_ticks     <= RST_RESET_LOW;
      cfg_q.presence_wait_ticks <= RST_PRESENCE_WAIT;
      cfg_q.reset_recover_ticks <= RST_RESET_RECOVER;
      cfg_q.write_low_ticks     <= RST_WRITE_LOW;
      cfg_q.write_hold_ticks    <= RST_WRITE_HOLD;
      cfg_q.read_low_ticks      <= RST_READ_LOW;
      cfg_q.read_sample_ticks   <= RST_READ_SAMPLE;
      cfg_q.read_recover_ticks  <= RST_READ_RECOVER;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/owb_sequencer.sv -----
module owb_sequencer
  import owb_pkg::*;
#(
  parameter int COUNT_BITS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  owb_item_t item_i,
  input  owb_cfg_t  cfg_i,
  output owb_res_t  res_o
);

  localparam int CmpW = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
  localparam logic [CmpW-1:0] CountMax = CmpW'((64'd1 << COUNT_BITS) - 64'd1);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_RST_LOW  = 4'd1;
  localparam logic [3:0] PH_RST_WAIT = 4'd2;
  localparam logic [3:0] PH_RST_REC  = 4'd3;
  localparam logic [3:0] PH_WR_LOW   = 4'd4;
  localparam logic [3:0] PH_WR_HOLD  = 4'd5;
  localparam logic [3:0] PH_RD_LOW   = 4'd6;
  localparam logic [3:0] PH_RD_WAIT  = 4'd7;
  localparam logic [3:0] PH_RD_REC   = 4'd8;

  logic [3:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic [2:0]            bit_q, bit_d;
  logic [BYTE_W-1:0]     send_q, send_d;
  logic [BYTE_W-1:0]     recv_q, recv_d;
  logic                  pres_q, pres_d;
  logic [REG_W-1:0]      len_raw;
  logic [CmpW-1:0]       len_w;
  logic                  done;
  logic                  low;

  // phase length for the current phase
  always_comb begin
    unique case (phase_q)
      PH_RST_LOW:  len_raw = cfg_i.reset_low_ticks;
      PH_RST_WAIT: len_raw = cfg_i.presence_wait_ticks;
      PH_RST_REC:  len_raw = cfg_i.reset_recover_ticks;
      PH_WR_LOW:   len_raw = cfg_i.write_low_ticks;
      PH_WR_HOLD:  len_raw = cfg_i.write_hold_ticks;
      PH_RD_LOW:   len_raw = cfg_i.read_low_ticks;
      PH_RD_WAIT:  len_raw = cfg_i.read_sample_ticks;
      PH_RD_REC:   len_raw = cfg_i.read_recover_ticks;
      default:     len_raw = REG_W'(1);
    endcase
    len_w = CmpW'(len_raw);
    if (len_raw == '0) len_w = CmpW'(1);
    if (len_w > CountMax) len_w = CountMax;
  end

  assign cnt_inc = cnt_q + COUNT_BITS'(1);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    send_d  = send_q;
    recv_d  = recv_q;
    pres_d  = pres_q;
    done    = 1'b0;
    if (phase_q == PH_IDLE || phase_q > PH_RD_REC) begin
      phase_d = PH_IDLE;
      cnt_d   = '0;
      bit_d   = '0;
      case (item_i.cmd)
        CMD_RESET: phase_d = PH_RST_LOW;
        CMD_WRITE: begin
          send_d  = item_i.data_byte;
          phase_d = PH_WR_LOW;
        end
        CMD_READ: begin
          recv_d  = '0;
          phase_d = PH_RD_LOW;
        end
        default: phase_d = PH_IDLE;
      endcase
    end else begin
      cnt_d = cnt_inc;
      if (CmpW'(cnt_inc) >= len_w) begin
        cnt_d = '0;
        unique case (phase_q)
          PH_RST_LOW: phase_d = PH_RST_WAIT;
          PH_RST_WAIT: begin
            pres_d  = item_i.line_in;
            phase_d = PH_RST_REC;
          end
          PH_WR_LOW: phase_d = PH_WR_HOLD;
          PH_RD_LOW: phase_d = PH_RD_WAIT;
          PH_RD_WAIT: begin
            recv_d[bit_q] = recv_q[bit_q] | item_i.line_in;
            phase_d       = PH_RD_REC;
          end
          PH_WR_HOLD, PH_RD_REC: begin
            if (bit_q == 3'd7) begin
              bit_d   = '0;
              phase_d = PH_IDLE;
              done    = 1'b1;
            end else begin
              bit_d = bit_q + 3'd1;
              if (phase_q == PH_WR_HOLD) begin
                send_d  = send_q >> 1;
                phase_d = PH_WR_LOW;
              end else begin
                phase_d = PH_RD_LOW;
              end
            end
          end
          default: begin
            // end of reset recovery
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    case (phase_d)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: low = 1'b1;
      PH_WR_HOLD:                       low = ~send_d[0];
      default:                          low = 1'b0;
    endcase
  end

  assign res_o.bus_low        = low;
  assign res_o.busy_res       = (phase_d != PH_IDLE);
  assign res_o.done_res       = done;
  assign res_o.read_byte      = recv_d;
  assign res_o.presence_level = pres_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
      send_q  <= '0;
      recv_q  <= '0;
      pres_q  <= 1'b1;
    end else if (adv_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      send_q  <= send_d;
      recv_q  <= recv_d;
      pres_q  <= pres_d;
    end
  end

endmodule

// ----- rtl/owb_checker.sv -----
module owb_checker
  import owb_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // a finished sequence is no longer busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1])
    else $error("done reported while busy");

  // line is released on the done tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[0])
    else $error("line driven low on done");

  // the line is pulled low only by a running sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("line driven low while idle");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind one_wire_bus_master owb_checker u_owb_checker (.*);

// ----- verif/tb_one_wire_bus_master.sv -----
`timescale 1ns / 100ps

module tb_one_wire_bus_master;
  import owb_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_REC,
    PH_WR_LOW,
    PH_WR_HOLD,
    PH_RD_LOW,
    PH_RD_WAIT,
    PH_RD_REC
  } seq_phase_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0]     s_axis_tuser = CMD_TICK;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i = '0;
  logic [REG_W-1:0]     cfg_data_i = '0;

  one_wire_bus_master uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // bus sequencer mirror
  logic [REG_W-1:0] cfg_ticks [NUM_REGS];
  seq_phase_e       seq_ph;
  logic [REG_W-1:0] tick_cnt;
  logic [2:0]       bit_idx;
  logic [7:0]       tx_shift;
  logic [7:0]       rx_shift;
  logic             presence;

  owb_item_t   item_q [$];
  owb_res_t    status_q [$];
  int unsigned items_queued = 0;
  int unsigned status_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  int unsigned src_gap = 0;
  int unsigned src_burst = 0;
  int unsigned sink_gap = 0;
  int unsigned sink_burst = 0;
  owb_item_t   drv_item;
  owb_res_t    drv_status;
  owb_res_t    want;
  logic        nxt_valid;

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic logic [REG_W-1:0] phase_ticks(seq_phase_e ph);
    logic [REG_W-1:0] t;
    case (ph)
      PH_RST_LOW:  t = cfg_ticks[REG_RESET_LOW];
      PH_RST_WAIT: t = cfg_ticks[REG_PRESENCE_WAIT];
      PH_RST_REC:  t = cfg_ticks[REG_RESET_RECOVER];
      PH_WR_LOW:   t = cfg_ticks[REG_WRITE_LOW];
      PH_WR_HOLD:  t = cfg_ticks[REG_WRITE_HOLD];
      PH_RD_LOW:   t = cfg_ticks[REG_READ_LOW];
      PH_RD_WAIT:  t = cfg_ticks[REG_READ_SAMPLE];
      PH_RD_REC:   t = cfg_ticks[REG_READ_RECOVER];
      default:     t = 10'd1;
    endcase
    return (t == '0) ? 10'd1 : t;
  endfunction

  function automatic void bus_reset_state();
    cfg_ticks[REG_RESET_LOW]     = RST_RESET_LOW;
    cfg_ticks[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
    cfg_ticks[REG_RESET_RECOVER] = RST_RESET_RECOVER;
    cfg_ticks[REG_WRITE_LOW]     = RST_WRITE_LOW;
    cfg_ticks[REG_WRITE_HOLD]    = RST_WRITE_HOLD;
    cfg_ticks[REG_READ_LOW]      = RST_READ_LOW;
    cfg_ticks[REG_READ_SAMPLE]   = RST_READ_SAMPLE;
    cfg_ticks[REG_READ_RECOVER]  = RST_READ_RECOVER;
    seq_ph   = PH_IDLE;
    tick_cnt = '0;
    bit_idx  = '0;
    tx_shift = '0;
    rx_shift = '0;
    presence = 1'b1;
  endfunction

  // one tick of the sequencer; returns the line drive and status it shows
  function automatic owb_res_t bus_step(logic [CMD_W-1:0] cmd, logic [7:0] data, logic line);
    owb_res_t r;
    logic     done;
    done = 1'b0;
    if (seq_ph == PH_IDLE) begin
      bit_idx  = '0;
      tick_cnt = '0;
      case (cmd)
        CMD_RESET: seq_ph = PH_RST_LOW;
        CMD_WRITE: begin
          tx_shift = data;
          seq_ph   = PH_WR_LOW;
        end
        CMD_READ: begin
          rx_shift = '0;
          seq_ph   = PH_RD_LOW;
        end
        default: ;
      endcase
    end else begin
      // commands are ignored here: the tick only advances the timing
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= phase_ticks(seq_ph)) begin
        tick_cnt = '0;
        case (seq_ph)
          PH_RST_LOW:  seq_ph = PH_RST_WAIT;
          PH_RST_WAIT: begin
            presence = line;
            seq_ph   = PH_RST_REC;
          end
          PH_WR_LOW:   seq_ph = PH_WR_HOLD;
          PH_RD_LOW:   seq_ph = PH_RD_WAIT;
          PH_RD_WAIT: begin
            if (line) rx_shift[bit_idx] = 1'b1;
            seq_ph = PH_RD_REC;
          end
          PH_WR_HOLD, PH_RD_REC: begin
            if (bit_idx == 3'd7) begin
              bit_idx = '0;
              seq_ph  = PH_IDLE;
              done    = 1'b1;
            end else begin
              bit_idx = bit_idx + 3'd1;
              if (seq_ph == PH_WR_HOLD) begin
                tx_shift = tx_shift >> 1;
                seq_ph   = PH_WR_LOW;
              end else begin
                seq_ph = PH_RD_LOW;
              end
            end
          end
          default: begin
            seq_ph = PH_IDLE;
            done   = 1'b1;
          end
        endcase
      end
    end
    case (seq_ph)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: r.bus_low = 1'b1;
      PH_WR_HOLD: r.bus_low = ~tx_shift[0];
      default:    r.bus_low = 1'b0;
    endcase
    r.busy_res       = (seq_ph != PH_IDLE);
    r.done_res       = done;
    r.read_byte      = rx_shift;
    r.presence_level = presence;
    return r;
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int unsigned pick_gap(inout int unsigned burst);
    int unsigned r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CMD_W-1:0] rand_cmd();
    case ($urandom_range(0, 2))
      0:       return CMD_RESET;
      1:       return CMD_WRITE;
      default: return CMD_READ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0d status #%0d: %s", cycle_cnt, status_seen, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
  endtask

  // command stream driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= CMD_TICK;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        drv_status = bus_step(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
        status_q.push_back(drv_status);
        src_gap = pick_gap(src_burst);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        nxt_valid = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (item_q.size() != 0) begin
          drv_item = item_q.pop_front();
          s_axis_tdata <= {{(S_TDATA_W - 9){1'b0}}, drv_item.line_in, drv_item.data_byte};
          s_axis_tuser <= drv_item.cmd;
          nxt_valid = 1'b1;
        end
        s_axis_tvalid <= nxt_valid;
      end
    end
  end

  // status stream monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction %0h", m_axis_tdata));
        end else begin
          want = status_q.pop_front();
          check_field("bus_low", m_axis_tdata[0], want.bus_low);
          check_field("busy_res", m_axis_tdata[1], want.busy_res);
          check_field("done_res", m_axis_tdata[2], want.done_res);
          check_field("read_byte", m_axis_tdata[10:3], want.read_byte);
          check_field("presence_level", m_axis_tdata[11], want.presence_level);
        end
        status_seen++;
        sink_gap = pick_gap(sink_burst);
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic add_item(logic [CMD_W-1:0] cmd, logic [7:0] data, logic line);
    owb_item_t it;
    it.cmd       = cmd;
    it.data_byte = data;
    it.line_in   = line;
    item_q.push_back(it);
    items_queued++;
  endtask

  // level 0/1 holds the line there, anything else randomizes it;
  // noisy slips in stray commands
  task automatic add_ticks(int n, int level, bit noisy);
    logic [CMD_W-1:0] c;
    logic             l;
    for (int i = 0; i < n; i++) begin
      c = (noisy && $urandom_range(0, 99) < 5) ? rand_cmd() : CMD_TICK;
      l = (level > 1) ? 1'($urandom) : 1'(level);
      add_item(c, 8'($urandom), l);
    end
  endtask

  task automatic wait_drained();
    while (status_seen < items_queued) @(posedge clk_i);
  endtask

  // feed ticks until the running sequence has ended and all status is back
  task automatic settle_bus();
    forever begin
      wait_drained();
      if (seq_ph == PH_IDLE) break;
      add_ticks(16, 2, 1'b0);
    end
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_ticks[idx] = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(logic [REG_W-1:0] val);
    for (int i = 0; i < NUM_REGS; i++) write_reg(REG_IDX_W'(i), val);
  endtask

  initial begin
    int unsigned start;
    bus_reset_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // power-up tick counts: first read slot, first write slot, start of a reset;
    // each sequence is then cut short by shrinking its own phases
    add_item(CMD_READ, 8'h00, 1'b1);
    add_ticks(66, 2, 1'b0);
    wait_drained();
    write_reg(REG_READ_LOW, 10'd1);
    write_reg(REG_READ_SAMPLE, 10'd1);
    write_reg(REG_READ_RECOVER, 10'd1);
    settle_bus();
    add_item(CMD_WRITE, 8'hA5, 1'b1);
    add_ticks(62, 2, 1'b0);
    wait_drained();
    write_reg(REG_WRITE_LOW, 10'd1);
    write_reg(REG_WRITE_HOLD, 10'd1);
    settle_bus();
    add_item(CMD_RESET, 8'h00, 1'b0);
    add_ticks(20, 2, 1'b0);
    wait_drained();
    write_reg(REG_RESET_LOW, 10'd1);
    write_reg(REG_PRESENCE_WAIT, 10'd1);
    write_reg(REG_RESET_RECOVER, 10'd1);
    settle_bus();

    // shortest timing: bytes at both ends, fixed line levels, commands while busy
    write_all(10'd1);
    add_item(CMD_TICK, 8'hFF, 1'b1);
    add_item(CMD_WRITE, 8'h00, 1'b0);
    add_item(CMD_READ, 8'hFF, 1'b1);
    settle_bus();
    add_item(CMD_WRITE, 8'hFF, 1'b1);
    settle_bus();
    add_item(CMD_READ, 8'h00, 1'b0);
    add_ticks(30, 0, 1'b0);
    settle_bus();
    add_item(CMD_READ, 8'h00, 1'b1);
    add_ticks(30, 1, 1'b0);
    settle_bus();
    add_item(CMD_RESET, 8'h00, 1'b0);
    add_ticks(5, 0, 1'b0);
    settle_bus();
    add_item(CMD_RESET, 8'h00, 1'b1);
    add_ticks(5, 1, 1'b0);
    settle_bus();
    // back-to-back commands: ignored until the write ends, then a read starts
    add_item(CMD_WRITE, 8'h5A, 1'b0);
    repeat (20) add_item(CMD_READ, 8'h3C, 1'b1);
    settle_bus();

    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < NUM_REGS; i++)
        write_reg(REG_IDX_W'(i), ($urandom_range(0, 99) < 85) ?
                  REG_W'($urandom_range(1, 4)) : REG_W'($urandom_range(5, 40)));
      start = items_queued;
      while (items_queued - start < 80) begin
        add_item(rand_cmd(), 8'($urandom), 1'($urandom));
        add_ticks($urandom_range(0, 40), 2, 1'b1);
      end
      settle_bus();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
